// File: rtl/core/b58enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58enc_pkg
// Shared types, constants and the alphabet lookup for the base58 encoder.
// ----------------------------------------------------------------------------
package b58enc_pkg;

    localparam int DIGIT_DEPTH   = 44;   // base-58 digit store entries
    localparam int RESULT_CAP    = 44;   // most symbols one message may give
    localparam int MAX_BYTES_DEF = 32;
    localparam int RADIX         = 58;
    localparam int DIGIT_W       = 6;
    localparam int IDX_W         = 6;
    localparam int LZ_W          = 6;
    localparam int CNT_W         = 7;
    localparam int CARRY_W       = 9;    // carry stays at or below 255
    localparam int VAL_W         = 15;   // digit * 256 + carry
    localparam int SYM_W         = 7;
    localparam int BYTE_W        = 8;

    // floor(v / 58) == (v * RECIP58) >> RECIP_SHIFT for every v below 2**15
    localparam int RECIP58       = 18079;
    localparam int RECIP_SHIFT   = 20;

    localparam logic [SYM_W-1:0] SYM_ONE = 7'h31;

    localparam logic [8*RADIX-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_symbol;
        logic             too_long;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic fold_init;
        logic fold_step;
        logic emit_init;
        logic load_err;
        logic load_one;
        logic dig_read;
        logic load_digit;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fold_pend;
        logic last;
        logic fold_busy;
        logic err;
        logic lz_zero;
        logic lz_one;
        logic dc_zero;
        logic idx_one;
        logic out_free;
    } status_t;

    function automatic logic [SYM_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dd;
        dd = (d > DIGIT_W'(RADIX - 1)) ? '0 : d;
        return ALPHABET[(RADIX - 1 - int'(dd)) * 8 +: SYM_W];
    endfunction

endpackage

// File: rtl/core/b58enc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58enc_dp
// Datapath: digit memory, digit multiply-add with divide by 58, message
// counters and the result output register.
// ----------------------------------------------------------------------------
module b58enc_dp #(
    parameter int MAX_BYTES = b58enc_pkg::MAX_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b58enc_pkg::cmd_t      cmd,
    output b58enc_pkg::status_t   st,
    input  b58enc_pkg::in_item_t  s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output b58enc_pkg::out_item_t m_data
);

    localparam int DW  = b58enc_pkg::DIGIT_W;
    localparam int IW  = b58enc_pkg::IDX_W;
    localparam int VW  = b58enc_pkg::VAL_W;
    localparam int CW  = b58enc_pkg::CARRY_W;
    localparam int PW  = 2 * VW;

    logic [DW-1:0] digit_mem [b58enc_pkg::DIGIT_DEPTH];
    logic [DW-1:0] rdata_reg;

    logic [b58enc_pkg::CNT_W-1:0] byte_count_reg;
    logic [b58enc_pkg::LZ_W-1:0]  lz_reg;
    logic                         nz_reg;
    logic                         ovf_reg;
    logic                         fold_pend_reg;
    logic                         last_reg;
    logic [IW-1:0]                dc_reg;
    logic [IW-1:0]                idx_reg;
    logic [CW-1:0]                carry_reg;
    b58enc_pkg::out_item_t        out_reg;
    logic                         out_valid_reg;

    logic          in_range;
    logic          room;
    logic [DW-1:0] digit;
    logic [VW-1:0] val;
    logic [PW-1:0] prod;
    logic [CW-1:0] quo;
    logic [VW-1:0] quo58;
    logic [VW-1:0] rem_full;
    logic          wr_en;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] idx_inc;
    logic [IW:0]   sym_total;
    logic          out_free;
    logic          take_fold;

    // one digit of the fold: val = digit * 256 + carry, split by 58
    assign in_range = idx_reg < dc_reg;
    assign room     = idx_reg < IW'(b58enc_pkg::DIGIT_DEPTH);
    assign digit    = in_range ? rdata_reg : '0;
    assign val      = (VW'(digit) << 8) + VW'(carry_reg);
    assign prod     = PW'(val) * PW'(b58enc_pkg::RECIP58);
    assign quo      = prod[b58enc_pkg::RECIP_SHIFT +: CW];
    assign quo58    = (VW'(quo) << 5) + (VW'(quo) << 4) + (VW'(quo) << 3) + (VW'(quo) << 1);
    assign rem_full = val - quo58;

    assign wr_en   = cmd.fold_step && room;
    assign idx_inc = idx_reg + IW'(1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.fold_init) begin
            rd_en = 1'b1;
        end else if (cmd.fold_step && idx_inc < IW'(b58enc_pkg::DIGIT_DEPTH)) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc;
        end else if (cmd.dig_read) begin
            rd_en   = 1'b1;
            rd_addr = idx_reg - IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[idx_reg] <= rem_full[DW-1:0];
        end
        if (rd_en) begin
            rdata_reg <= digit_mem[rd_addr];
        end
    end

    assign take_fold = !ovf_reg && byte_count_reg < b58enc_pkg::CNT_W'(MAX_BYTES)
                       && (nz_reg || s_data.data_byte != '0);
    assign out_free  = !out_valid_reg || m_ready;
    assign sym_total = {1'b0, lz_reg} + {1'b0, dc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            lz_reg         <= '0;
            nz_reg         <= 1'b0;
            ovf_reg        <= 1'b0;
            fold_pend_reg  <= 1'b0;
            last_reg       <= 1'b0;
            dc_reg         <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.take) begin
                last_reg      <= s_data.last_byte;
                fold_pend_reg <= take_fold;
                if (!ovf_reg) begin
                    if (byte_count_reg >= b58enc_pkg::CNT_W'(MAX_BYTES)) begin
                        ovf_reg <= 1'b1;
                    end else begin
                        byte_count_reg <= byte_count_reg + b58enc_pkg::CNT_W'(1);
                        if (!nz_reg && s_data.data_byte == '0) begin
                            lz_reg <= lz_reg + b58enc_pkg::LZ_W'(1);
                        end else begin
                            nz_reg <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.fold_init) begin
                idx_reg <= '0;
            end
            if (cmd.fold_step) begin
                if (!in_range && !room) begin
                    ovf_reg <= 1'b1;   // digit store full, carry left over
                end else begin
                    idx_reg <= idx_inc;
                    if (!in_range) begin
                        dc_reg <= dc_reg + IW'(1);
                    end
                end
            end
            if (cmd.emit_init) begin
                idx_reg <= dc_reg;
            end
            if (cmd.load_one) begin
                lz_reg <= lz_reg - b58enc_pkg::LZ_W'(1);
            end
            if (cmd.load_digit) begin
                idx_reg <= idx_reg - IW'(1);
            end
            if (cmd.load_err || cmd.load_one || cmd.load_digit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear) begin
                byte_count_reg <= '0;
                lz_reg         <= '0;
                nz_reg         <= 1'b0;
                ovf_reg        <= 1'b0;
                dc_reg         <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            carry_reg <= CW'(s_data.data_byte);
        end else if (cmd.fold_step) begin
            carry_reg <= quo;
        end
        if (cmd.load_err) begin
            out_reg.symbol      <= '0;
            out_reg.last_symbol <= 1'b0;
            out_reg.too_long    <= 1'b1;
        end else if (cmd.load_one) begin
            out_reg.symbol      <= b58enc_pkg::SYM_ONE;
            out_reg.last_symbol <= (lz_reg == b58enc_pkg::LZ_W'(1)) && (dc_reg == '0);
            out_reg.too_long    <= 1'b0;
        end else if (cmd.load_digit) begin
            out_reg.symbol      <= b58enc_pkg::b58_char(rdata_reg);
            out_reg.last_symbol <= idx_reg == IW'(1);
            out_reg.too_long    <= 1'b0;
        end
    end

    assign st.fold_pend = fold_pend_reg;
    assign st.last      = last_reg;
    assign st.fold_busy = (in_range || carry_reg != '0) && !ovf_reg;
    assign st.err       = ovf_reg || sym_total > (IW + 1)'(b58enc_pkg::RESULT_CAP);
    assign st.lz_zero   = lz_reg == '0;
    assign st.lz_one    = lz_reg == b58enc_pkg::LZ_W'(1);
    assign st.dc_zero   = dc_reg == '0;
    assign st.idx_one   = idx_reg == IW'(1);
    assign st.out_free  = out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_dc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dc_reg <= IW'(b58enc_pkg::DIGIT_DEPTH))
        else $error("digit count beyond digit store");

    a_byte_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= b58enc_pkg::CNT_W'(MAX_BYTES))
        else $error("byte count beyond message limit");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (dc_reg == '0 && lz_reg == '0 && !ovf_reg && byte_count_reg == '0))
        else $error("message state not cleared");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.too_long |-> !out_reg.last_symbol && out_reg.symbol == '0)
        else $error("malformed error result");

endmodule

// File: rtl/core/b58enc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58enc_ctrl
// Controller: sequences byte intake, the digit fold and symbol emission.
// ----------------------------------------------------------------------------
module b58enc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b58enc_pkg::status_t st,
    output b58enc_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FOLD,
        ST_FINAL,
        ST_ERR,
        ST_ONES,
        ST_DIG_RD,
        ST_DIG_LOAD,
        ST_CLEAR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (st.fold_pend) begin
                    cmd.fold_init = 1'b1;
                    state_next    = ST_FOLD;
                end else begin
                    state_next = st.last ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FOLD: begin
                if (st.fold_busy) begin
                    cmd.fold_step = 1'b1;
                end else begin
                    state_next = st.last ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (st.err) begin
                    state_next = ST_ERR;
                end else begin
                    cmd.emit_init = 1'b1;
                    if (!st.lz_zero) begin
                        state_next = ST_ONES;
                    end else if (!st.dc_zero) begin
                        state_next = ST_DIG_RD;
                    end else begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_ERR: begin
                if (st.out_free) begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            ST_ONES: begin
                if (st.out_free) begin
                    cmd.load_one = 1'b1;
                    if (st.lz_one) begin
                        state_next = st.dc_zero ? ST_CLEAR : ST_DIG_RD;
                    end
                end
            end
            ST_DIG_RD: begin
                cmd.dig_read = 1'b1;
                state_next   = ST_DIG_LOAD;
            end
            ST_DIG_LOAD: begin
                if (st.out_free) begin
                    cmd.load_digit = 1'b1;
                    state_next     = st.idx_one ? ST_CLEAR : ST_DIG_RD;
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

endmodule

// File: rtl/core/base58_encoder_core.sv
`timescale 1ns / 1ps
// sequencing: a byte that folds passes through take, check and one fold step per base-58 digit it
//   touches (stored digits plus new ones); a byte that does not fold only through take and check
// after the last byte: one load per leading '1', a read and a load per digit symbol (single read
//   port), then clear; one byte in flight, a result may still wait meanwhile
// reset: synchronous active-low aresetn clears control and counters; the digit
//   memory needs no clearing, only entries below the digit count are read
// ----------------------------------------------------------------------------
// base58_encoder_core
// Base58 (bitcoin alphabet) encoder top level: controller plus datapath.
// ----------------------------------------------------------------------------
module base58_encoder_core #(
    parameter int MAX_BYTES = b58enc_pkg::MAX_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input byte transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b58enc_pkg::in_item_t  s_data,
    // symbol transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output b58enc_pkg::out_item_t m_data
);

    // command and status between controller and datapath
    b58enc_pkg::cmd_t    cmd;
    b58enc_pkg::status_t st;

    // sequencer: intake, fold loop, emission
    b58enc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // digit store, multiply-add by 256 and divide by 58, output register
    b58enc_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base58_encoder_core. Byte messages go in over the
// s_ channel and every symbol coming back on the m_ channel is checked against
// a predictor that keeps its own base-58 digit store. Directed messages cover
// single bytes, leading zeros, trailing zeros, full-length and over-length
// messages; random messages follow with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MSG_LIMIT    = b58enc_pkg::MAX_BYTES_DEF;
    localparam int DIGIT_W      = b58enc_pkg::DIGIT_W;
    localparam int DIGIT_DEPTH  = b58enc_pkg::DIGIT_DEPTH;
    localparam int RADIX        = b58enc_pkg::RADIX;
    localparam int RESULT_CAP   = b58enc_pkg::RESULT_CAP;
    localparam int BYTE_W       = b58enc_pkg::BYTE_W;
    localparam int ITEM_TARGET  = 280;
    localparam int IDLE_PCT     = 37;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_PRINTS   = 100;

    // predicts the symbols of each message and holds them until they come back
    class base58_symbol_board;
        logic [DIGIT_W-1:0]    digits [DIGIT_DEPTH];
        int unsigned           digit_count;
        int unsigned           zero_symbols;
        int unsigned           taken;
        int unsigned           max_bytes;
        bit                    nonzero_seen;
        bit                    too_long;
        b58enc_pkg::out_item_t expected_symbols [$];
        int unsigned           mismatch_count;
        string                 symbol_set;

        function new(int unsigned limit);
            max_bytes      = limit;
            mismatch_count = 0;
            symbol_set     = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
            clear_message();
        endfunction

        function void clear_message();
            digit_count  = 0;
            zero_symbols = 0;
            taken        = 0;
            nonzero_seen = 0;
            too_long     = 0;
        endfunction

        // number = number * 256 + value, carries divided down the digit store
        function void fold_into_digits(int unsigned value);
            int unsigned carry;
            int unsigned v;
            carry = value;
            for (int unsigned i = 0; i < digit_count; i++) begin
                v         = int'(digits[i]) * 256 + carry;
                digits[i] = DIGIT_W'(v % RADIX);
                carry     = v / RADIX;
            end
            while (carry != 0) begin
                if (digit_count >= DIGIT_DEPTH) begin
                    too_long = 1;
                    return;
                end
                digits[digit_count] = DIGIT_W'(carry % RADIX);
                digit_count++;
                carry = carry / RADIX;
            end
        endfunction

        function void note_byte(b58enc_pkg::in_item_t item);
            b58enc_pkg::out_item_t sym;
            byte                   ch;
            int unsigned           total;
            int unsigned           d;
            if (!too_long) begin
                if (taken >= max_bytes) begin
                    too_long = 1;
                end else begin
                    taken++;
                    if (!nonzero_seen && item.data_byte == 8'h00) begin
                        zero_symbols++;
                    end else begin
                        nonzero_seen = 1;
                        fold_into_digits(item.data_byte);
                    end
                end
            end
            if (!item.last_byte) return;
            if (!too_long && zero_symbols + digit_count > RESULT_CAP) too_long = 1;
            if (too_long) begin
                sym          = '0;
                sym.too_long = 1'b1;
                expected_symbols.push_back(sym);
            end else begin
                // leading '1' symbols first, then digits most significant first
                total = zero_symbols + digit_count;
                for (int unsigned n = 0; n < total; n++) begin
                    d               = (n < zero_symbols) ? 0 : int'(digits[total - 1 - n]);
                    ch              = symbol_set[d];
                    sym.symbol      = ch[6:0];
                    sym.last_symbol = (n == total - 1);
                    sym.too_long    = 1'b0;
                    expected_symbols.push_back(sym);
                end
            end
            clear_message();
        endfunction

        task report(string what);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_symbol(b58enc_pkg::out_item_t got);
            b58enc_pkg::out_item_t want;
            if (expected_symbols.size() == 0) begin
                report($sformatf("unexpected symbol %h last %b too_long %b",
                                 got.symbol, got.last_symbol, got.too_long));
                return;
            end
            want = expected_symbols.pop_front();
            if (got.symbol !== want.symbol || got.last_symbol !== want.last_symbol ||
                got.too_long !== want.too_long)
                report($sformatf("got symbol %h last %b too_long %b, want %h %b %b",
                                 got.symbol, got.last_symbol, got.too_long,
                                 want.symbol, want.last_symbol, want.too_long));
        endtask

        function int unsigned outstanding();
            return expected_symbols.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    b58enc_pkg::in_item_t  s_data;
    logic                  m_valid;
    logic                  m_ready;
    b58enc_pkg::out_item_t m_data;

    base58_symbol_board board;
    logic [BYTE_W-1:0]  msg [$];
    bit                 steady;
    int unsigned        payload_bytes;
    int unsigned        cycle_count;

    base58_encoder_core #(
        .MAX_BYTES (MSG_LIMIT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base58_encoder_core test failed");
            $finish;
        end
    end

    // result side: random back-pressure, none during the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_symbol(m_data);
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // one byte transaction, with random gaps before it
    task automatic send_byte(b58enc_pkg::in_item_t item);
        @(negedge aclk);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(item);
    endtask

    task automatic send_message();
        b58enc_pkg::in_item_t item;
        for (int i = 0; i < msg.size(); i++) begin
            item.data_byte = msg[i];
            item.last_byte = (i == msg.size() - 1);
            send_byte(item);
            payload_bytes++;
        end
        msg.delete();
    endtask

    task automatic push_bytes(int unsigned count, int fill);
        for (int unsigned i = 0; i < count; i++)
            msg.push_back((fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill));
    endtask

    // hold the sender off until every predicted symbol has come back
    task automatic drain_symbols();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
    endtask

    task automatic build_random_message();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 10) begin
            push_bytes($urandom_range(4, 1), 0);
            push_bytes($urandom_range(6, 1), -1);
        end else if (kind < 15) begin
            push_bytes($urandom_range(6, 1), 0);
        end else if (kind < 20) begin
            push_bytes($urandom_range(MSG_LIMIT, MSG_LIMIT - 8), -1);
        end else if (kind < 24) begin
            push_bytes($urandom_range(MSG_LIMIT + 6, MSG_LIMIT + 1), -1);
        end else if (kind < 30) begin
            for (int i = $urandom_range(8, 1); i > 0; i--)
                msg.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        end else begin
            push_bytes($urandom_range(8, 1), -1);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        steady        = 1'b0;
        payload_bytes = 0;
        cycle_count   = 0;
        board         = new(MSG_LIMIT);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single bytes: zero, extremes, last one-digit value and first two-digit value
        msg = '{8'h00};             send_message();
        msg = '{8'hFF};             send_message();
        msg = '{8'h01};             send_message();
        msg = '{8'h39};             send_message();
        msg = '{8'h3A};             send_message();
        // leading zeros, trailing zeros, zeros on both sides
        msg = '{8'h00, 8'h00, 8'h05}; send_message();
        msg = '{8'h01, 8'h00};        send_message();
        msg = '{8'h00, 8'hFF, 8'h00}; send_message();
        msg = '{8'h80, 8'h7F};        send_message();
        drain_symbols();

        // full-length messages: most digits, most '1' symbols
        push_bytes(MSG_LIMIT, 8'hFF); send_message();
        push_bytes(MSG_LIMIT, 8'h00); send_message();
        push_bytes(MSG_LIMIT, -1);    send_message();
        // one byte too many, then a longer one whose tail is ignored
        push_bytes(MSG_LIMIT + 1, -1); send_message();
        push_bytes(MSG_LIMIT + 8, -1); send_message();
        // the next message must start from clean state
        msg = '{8'h2A};               send_message();

        // random messages until the byte budget is spent
        while (payload_bytes < ITEM_TARGET) begin
            steady = (payload_bytes >= 190 && payload_bytes < 250);
            build_random_message();
            send_message();
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatch_count == 0 && board.outstanding() == 0) begin
            $display("base58_encoder_core test passed");
        end else begin
            $display("base58_encoder_core test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/b58enc_pkg.sv
rtl/core/b58enc_dp.sv
rtl/core/b58enc_ctrl.sv
rtl/core/base58_encoder_core.sv
test/testbench.sv
